// ===== sv/utbs_pkg.sv =====
// utbs_pkg: shared types and codes of the uniform tile block store
// no dependencies

package utbs_pkg;

   localparam int FUNC_W     = 2;
   localparam int POS_W      = 4;
   localparam int SIZE_W     = 5;
   localparam int MAT_PORT_W = 8;

   localparam logic [FUNC_W-1:0] FUNC_SET_TILE  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILL_RECT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET_BLOCK = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } utbs_state_type;

   // tag that travels with one tile from its read to its write back
   typedef struct packed {
      logic valid;
      logic in_rect;
      logic first;
   } tile_tag_type;

endpackage

// ===== sv/uniform_tile_block_store.sv =====
// uniform_tile_block_store: square block of material tiles with a uniform form
// set whole block, no-change and error words get their registered answer in the cycle after accept
// a split or a write into a split block runs a pass over every tile:
// one memory read and one write back per tile, ending with the merge decision
// one word at a time; the next word is taken once the previous result is registered and the result register is free
// reset: block uniform with material zero; tile memory is not cleared
// depends on utbs_pkg, utbs_scan, utbs_tile_mem

module uniform_tile_block_store
   import utbs_pkg::*;
#(
   parameter int LINE_TILES    = 16,
   parameter int MATERIAL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [POS_W-1:0]      req_pos_x,
   input  logic [POS_W-1:0]      req_pos_y,
   input  logic [SIZE_W-1:0]     req_rect_width,
   input  logic [SIZE_W-1:0]     req_rect_height,
   input  logic [MAT_PORT_W-1:0] req_material,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_changed,
   output logic                  rsp_uniform,
   output logic [MAT_PORT_W-1:0] rsp_uniform_material,
   output logic                  rsp_range_error
);

   localparam int TILES = LINE_TILES * LINE_TILES;
   localparam int AW    = $clog2(TILES);
   localparam int MW    = MATERIAL_BITS;
   localparam int TAKE  = (MW < MAT_PORT_W) ? MW : MAT_PORT_W;
   localparam int CMP_W = ((SIZE_W + 1) > $clog2(LINE_TILES + 1)) ?
                          (SIZE_W + 1) : $clog2(LINE_TILES + 1);
   localparam logic [CMP_W-1:0] LT = CMP_W'(LINE_TILES);

   utbs_state_type state_ff, state_in;

   // block state
   logic          is_uniform_ff;
   logic [MW-1:0] block_material_ff;

   // pass operands
   logic             split_ff;
   logic [MW-1:0]    mat_ff;
   logic [CMP_W-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;

   // pass accumulators
   logic          changed_ff;
   logic          all_eq_ff;
   logic [MW-1:0] first_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_changed_ff;
   logic                  rsp_uniform_ff;
   logic [MAT_PORT_W-1:0] rsp_material_ff;
   logic                  rsp_error_ff;

   logic rsp_free, accept, scan_run, finish_load;

   // scan and memory connections
   logic [AW-1:0] rd_addr, wr_addr;
   logic          scan_last;
   tile_tag_type  tag;
   logic [MW-1:0] rd_data;

   // decode of the incoming word
   logic [MW-1:0]    req_mat;
   logic [CMP_W-1:0] px, py, rw, rh;
   logic dec_pass, dec_set_whole, dec_err, same;
   logic [CMP_W-1:0] dec_x_hi, dec_y_hi;

   assign req_mat = MW'(req_material[TAKE-1:0]);
   assign px      = CMP_W'(req_pos_x);
   assign py      = CMP_W'(req_pos_y);
   assign rw      = CMP_W'(req_rect_width);
   assign rh      = CMP_W'(req_rect_height);
   assign same    = is_uniform_ff && (block_material_ff == req_mat);

   always_comb begin
      dec_pass      = 1'b0;
      dec_set_whole = 1'b0;
      dec_err       = 1'b0;
      dec_x_hi      = px + rw;
      dec_y_hi      = py + rh;
      unique case (req_func)
         FUNC_SET_TILE: begin
            dec_x_hi = px + CMP_W'(1);
            dec_y_hi = py + CMP_W'(1);
            if ((px >= LT) || (py >= LT)) begin
               dec_err = 1'b1;
            end else if (!same) begin
               dec_pass = 1'b1;
            end
         end
         FUNC_FILL_RECT: begin
            if ((px == '0) && (py == '0) && (rw == LT) && (rh == LT)) begin
               dec_set_whole = 1'b1;
            end else if ((px + rw > LT) || (py + rh > LT)) begin
               dec_err = 1'b1;
            end else if (!same) begin
               dec_pass = 1'b1;
            end
         end
         FUNC_SET_BLOCK: begin
            dec_set_whole = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // state machine
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   utbs_scan #(
      .LINE_TILES (LINE_TILES)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .run     (scan_run),
      .x_lo    (x_lo_ff),
      .x_hi    (x_hi_ff),
      .y_lo    (y_lo_ff),
      .y_hi    (y_hi_ff),
      .rd_addr (rd_addr),
      .last    (scan_last),
      .wr_addr (wr_addr),
      .tag     (tag)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept && dec_pass) state_in = ST_SCAN;
         ST_SCAN:   if (scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      scan_run    = 1'b0;
      finish_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = rsp_free;
         ST_SCAN:   scan_run = 1'b1;
         ST_DRAIN:  ;
         ST_FINISH: finish_load = rsp_free;
         default:   ;
      endcase
   end

   // write-back stage: old value is the block material while splitting
   logic [MW-1:0] old_val, new_val;
   logic          diff;

   assign old_val = split_ff ? block_material_ff : rd_data;
   assign new_val = tag.in_rect ? mat_ff : old_val;
   assign diff    = tag.in_rect && (old_val != mat_ff);

   utbs_tile_mem #(
      .DEPTH (TILES),
      .AW    (AW),
      .DW    (MW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (tag.valid),
      .wr_addr (wr_addr),
      .wr_data (new_val),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic merged;
   assign merged = changed_ff && all_eq_ff;

   always_ff @(posedge clock) begin
      if (tag.valid) begin
         if (tag.first) begin
            first_ff   <= new_val;
            all_eq_ff  <= 1'b1;
            changed_ff <= diff;
         end else begin
            all_eq_ff  <= all_eq_ff && (new_val == first_ff);
            changed_ff <= changed_ff || diff;
         end
      end
      if (accept) begin
         split_ff <= is_uniform_ff;
         mat_ff   <= req_mat;
         x_lo_ff  <= px;
         y_lo_ff  <= py;
         x_hi_ff  <= dec_x_hi;
         y_hi_ff  <= dec_y_hi;
      end
      if (accept && !dec_pass) begin
         rsp_error_ff <= dec_err;
         if (dec_set_whole) begin
            rsp_changed_ff  <= !same;
            rsp_uniform_ff  <= 1'b1;
            rsp_material_ff <= MAT_PORT_W'(req_mat[TAKE-1:0]);
         end else begin
            rsp_changed_ff  <= 1'b0;
            rsp_uniform_ff  <= is_uniform_ff;
            rsp_material_ff <= is_uniform_ff ?
                               MAT_PORT_W'(block_material_ff[TAKE-1:0]) : '0;
         end
      end else if (finish_load) begin
         rsp_error_ff    <= 1'b0;
         rsp_changed_ff  <= changed_ff;
         rsp_uniform_ff  <= merged;
         rsp_material_ff <= merged ? MAT_PORT_W'(first_ff[TAKE-1:0]) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         is_uniform_ff     <= 1'b1;
         block_material_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && dec_set_whole) begin
            is_uniform_ff     <= 1'b1;
            block_material_ff <= req_mat;
         end else if (finish_load) begin
            is_uniform_ff     <= merged;
            block_material_ff <= first_ff;
         end
         if ((accept && !dec_pass) || finish_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_changed          = rsp_changed_ff;
   assign rsp_uniform          = rsp_uniform_ff;
   assign rsp_uniform_material = rsp_material_ff;
   assign rsp_range_error      = rsp_error_ff;

   // a tile write back only follows a read issued during the scan
   a_tag_from_scan: assert property (@(posedge clock) disable iff (reset)
      tag.valid |-> $past(state_ff == ST_SCAN))
      else $error("tile write back without a scan read");

   // read and write back never hit the same tile in one cycle
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (tag.valid && scan_run) |-> (wr_addr != rd_addr))
      else $error("read and write back overlap on one tile");

   // an out-of-range word changes nothing
   a_err_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_error_ff) |-> !rsp_changed_ff)
      else $error("range error reported with a change");

   // the block state only moves when a word is taken or a pass ends
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) || (state_ff == ST_DRAIN)) |=>
         ($stable(is_uniform_ff) && $stable(block_material_ff)))
      else $error("block state moved during a scan");

endmodule

// ===== sv/utbs_tile_mem.sv =====
// utbs_tile_mem: tile memory, one write port and one read port, registered read
// no dependencies

module utbs_tile_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/utbs_scan.sv =====
// utbs_scan: walks every tile in row order, issues reads and tags each tile
// with its rectangle membership; depends on utbs_pkg

module utbs_scan
   import utbs_pkg::*;
#(
   parameter int  LINE_TILES = 16,
   localparam int TILES      = LINE_TILES * LINE_TILES,
   localparam int AW         = $clog2(TILES),
   localparam int CMP_W      = ((SIZE_W + 1) > $clog2(LINE_TILES + 1)) ?
                               (SIZE_W + 1) : $clog2(LINE_TILES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                run,
   input  logic [CMP_W-1:0]    x_lo,
   input  logic [CMP_W-1:0]    x_hi,
   input  logic [CMP_W-1:0]    y_lo,
   input  logic [CMP_W-1:0]    y_hi,
   output logic [AW-1:0]       rd_addr,
   output logic                last,
   output logic [AW-1:0]       wr_addr,
   output tile_tag_type        tag
);

   localparam int CW    = $clog2(LINE_TILES);

   logic [CW-1:0] x_ff, x_in;
   logic [CW-1:0] y_ff, y_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] wr_addr_ff;
   tile_tag_type  tag_ff, tag_in;
   logic [CMP_W-1:0] x_ext, y_ext;

   assign x_ext = CMP_W'(x_ff);
   assign y_ext = CMP_W'(y_ff);
   assign last  = (addr_ff == AW'(TILES - 1));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      addr_in = addr_ff;
      if (start) begin
         x_in    = '0;
         y_in    = '0;
         addr_in = '0;
      end else if (run) begin
         addr_in = addr_ff + AW'(1);
         if (x_ff == CW'(LINE_TILES - 1)) begin
            x_in = '0;
            y_in = y_ff + CW'(1);
         end else begin
            x_in = x_ff + CW'(1);
         end
      end
   end

   always_comb begin
      tag_in.valid   = run;
      tag_in.in_rect = (x_ext >= x_lo) && (x_ext < x_hi) &&
                       (y_ext >= y_lo) && (y_ext < y_hi);
      tag_in.first   = (addr_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         addr_ff <= '0;
         tag_ff  <= '0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         addr_ff <= addr_in;
         tag_ff  <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= addr_ff;
   end

   assign rd_addr = addr_ff;
   assign wr_addr = wr_addr_ff;
   assign tag     = tag_ff;

endmodule
